[src/cbs_pkg.sv]
package cbs_pkg;

  localparam int BLOCK_COUNT   = 1024;
  localparam int BLOCK_BYTES   = 64;
  localparam int HEADER_BYTES  = 4;
  localparam int PAYLOAD_BYTES = BLOCK_BYTES - HEADER_BYTES;
  localparam int BLK_W         = $clog2(BLOCK_COUNT);
  localparam int CNT_W         = $clog2(BLOCK_COUNT + 1);
  localparam int POS_W         = $clog2(PAYLOAD_BYTES + 1);
  localparam int STORE_DEPTH   = BLOCK_COUNT * PAYLOAD_BYTES;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);
  localparam int LEN_W         = 16;
  localparam int STAMP_W       = 32;
  localparam int IN_TDATA_W    = 72;
  localparam int OUT_TDATA_W   = 64;

  typedef enum logic [1:0] {
    OP_PUT  = 2'd0,
    OP_READ = 2'd1,
    OP_DEL  = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [7:0]         data_byte;
    logic               last_byte;
    logic               begin_read;
    logic [BLK_W-1:0]   start_block;
    logic [LEN_W-1:0]   length_bytes;
    logic [STAMP_W-1:0] stamp_in;
  } item_t;

  // queue handshake between front and back
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_fwd_t;

  typedef struct packed {
    logic ready;
    logic hold;
  } q_bwd_t;

endpackage

[src/cbs_front.sv]
module cbs_front
  import cbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic [2:0]            in_tuser,
  input  logic                  in_tlast,
  output q_fwd_t                q_fwd,
  input  q_bwd_t                q_bwd
);

  item_t      mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  item_t      dec;
  logic       push, pop;

  // classify the incoming word
  always_comb begin
    dec.op           = op_t'(in_tuser[1:0]);
    dec.begin_read   = in_tuser[2];
    dec.last_byte    = in_tlast;
    dec.data_byte    = in_tdata[7:0];
    dec.start_block  = in_tdata[8 +: BLK_W];
    dec.length_bytes = in_tdata[18 +: LEN_W];
    dec.stamp_in     = in_tdata[34 +: STAMP_W];
  end

  assign in_tready = (cnt_r != 2'd2) && !q_bwd.hold;
  assign push      = in_tvalid && in_tready;
  assign q_fwd     = '{valid: (cnt_r != 2'd0), item: mem_r[rd_ptr_r]};
  assign pop       = q_fwd.valid && q_bwd.ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= dec;
    end
  end

endmodule

[src/cbs_back.sv]
module cbs_back
  import cbs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  q_fwd_t                 q_fwd,
  output q_bwd_t                 q_bwd,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser,
  output logic                   out_tlast
);

  typedef enum logic [7:0] {
    S_INIT      = 8'b0000_0001,
    S_IDLE      = 8'b0000_0010,
    S_PUT       = 8'b0000_0100,
    S_PUT_STAMP = 8'b0000_1000,
    S_RD_HDR    = 8'b0001_0000,
    S_RD_DATA   = 8'b0010_0000,
    S_DEL_PUSH  = 8'b0100_0000,
    S_DEL_NEXT  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0]       pay_mem  [STORE_DEPTH];
  logic [STAMP_W-1:0] hdr_mem [BLOCK_COUNT];
  logic [BLK_W-1:0] link_mem [BLOCK_COUNT];

  logic [7:0]         pay_rd_r;
  logic [STAMP_W-1:0] hdr_rd_r;
  logic [BLK_W-1:0]   link_rd_r;

  logic               pay_re, hdr_re, link_re;
  logic [ADDR_W-1:0]  pay_raddr, pay_waddr;
  logic [BLK_W-1:0]   hdr_raddr, hdr_waddr, link_raddr, link_waddr;
  logic               pay_we, hdr_we, link_we;
  logic [7:0]         pay_wdata;
  logic [STAMP_W-1:0] hdr_wdata;
  logic [BLK_W-1:0]   link_wdata;

  item_t            item_r, item_nxt;
  logic [BLK_W-1:0] init_cnt_r, init_cnt_nxt;
  logic [BLK_W-1:0] free_head_r, free_head_nxt;
  logic [CNT_W-1:0] free_total_r, free_total_nxt;
  logic [BLK_W-1:0] put_first_r, put_first_nxt;
  logic [BLK_W-1:0] put_cur_r, put_cur_nxt;
  logic [POS_W-1:0] put_fill_r, put_fill_nxt;
  logic             put_busy_r, put_busy_nxt;
  logic [BLK_W-1:0] rd_cur_r, rd_cur_nxt;
  logic [POS_W-1:0] rd_pos_r, rd_pos_nxt;
  logic [LEN_W-1:0] rd_left_r, rd_left_nxt;
  logic [BLK_W-1:0] del_blk_r, del_blk_nxt;
  logic [LEN_W-1:0] del_left_r, del_left_nxt;

  logic               ov_r, ov_nxt;
  logic               o_status_r, o_status_nxt;
  logic [BLK_W-1:0]   o_loc_r, o_loc_nxt;
  logic [7:0]         o_data_r, o_data_nxt;
  logic [STAMP_W-1:0] o_stamp_r, o_stamp_nxt;
  logic               o_eod_r, o_eod_nxt;
  logic [CNT_W-1:0]   o_free_r, o_free_nxt;

  logic             out_free;
  logic             need_pop;
  logic [BLK_W-1:0] put_blk;
  logic [POS_W-1:0] put_idx;

  assign out_free  = !ov_r || out_tready;
  assign need_pop  = !put_busy_r || (put_fill_r >= POS_W'(PAYLOAD_BYTES));
  assign put_blk   = (need_pop) ? free_head_r : put_cur_r;
  assign put_idx   = (need_pop) ? '0 : put_fill_r;

  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    init_cnt_nxt   = init_cnt_r;
    free_head_nxt  = free_head_r;
    free_total_nxt = free_total_r;
    put_first_nxt  = put_first_r;
    put_cur_nxt    = put_cur_r;
    put_fill_nxt   = put_fill_r;
    put_busy_nxt   = put_busy_r;
    rd_cur_nxt     = rd_cur_r;
    rd_pos_nxt     = rd_pos_r;
    rd_left_nxt    = rd_left_r;
    del_blk_nxt    = del_blk_r;
    del_left_nxt   = del_left_r;
    ov_nxt         = ov_r && !out_tready;
    o_status_nxt   = o_status_r;
    o_loc_nxt      = o_loc_r;
    o_data_nxt     = o_data_r;
    o_stamp_nxt    = o_stamp_r;
    o_eod_nxt      = o_eod_r;
    o_free_nxt     = o_free_r;
    q_bwd.ready    = 1'b0;
    q_bwd.hold     = (state_r == S_INIT);
    pay_re = 1'b0; pay_raddr = '0;
    hdr_re = 1'b0; hdr_raddr = '0;
    link_re = 1'b0; link_raddr = free_head_r;
    pay_we = 1'b0; pay_waddr = '0; pay_wdata = '0;
    hdr_we = 1'b0; hdr_waddr = '0; hdr_wdata = '0;
    link_we = 1'b0; link_waddr = '0; link_wdata = '0;

    unique case (state_r)
      S_INIT: begin
        // link table walk: entry i points at i + 1
        link_we      = 1'b1;
        link_waddr   = init_cnt_r;
        link_wdata   = init_cnt_r + 1'b1;
        init_cnt_nxt = init_cnt_r + 1'b1;
        if (init_cnt_r == BLK_W'(BLOCK_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_fwd.valid && out_free) begin
          q_bwd.ready = 1'b1;
          item_nxt    = q_fwd.item;
          unique case (q_fwd.item.op)
            OP_PUT: begin
              link_re    = 1'b1;
              link_raddr = free_head_r;
              state_nxt  = S_PUT;
            end
            OP_READ: begin
              if (q_fwd.item.begin_read) begin
                rd_cur_nxt  = q_fwd.item.start_block;
                rd_pos_nxt  = '0;
                rd_left_nxt = q_fwd.item.length_bytes;
              end
              hdr_re    = 1'b1;
              hdr_raddr = q_fwd.item.begin_read ? q_fwd.item.start_block : rd_cur_r;
              state_nxt = S_RD_HDR;
            end
            OP_DEL: begin
              del_blk_nxt  = q_fwd.item.start_block;
              del_left_nxt = q_fwd.item.length_bytes;
              state_nxt    = S_DEL_PUSH;
            end
            OP_NOP: begin
              ov_nxt       = 1'b1;
              o_status_nxt = 1'b0;
              o_loc_nxt    = '0;
              o_data_nxt   = '0;
              o_stamp_nxt  = '0;
              o_eod_nxt    = 1'b0;
              o_free_nxt   = free_total_r;
            end
            default: ;
          endcase
        end
      end
      S_PUT: begin
        o_loc_nxt   = '0;
        o_data_nxt  = '0;
        o_stamp_nxt = '0;
        o_eod_nxt   = 1'b0;
        if (need_pop && (free_total_r == '0)) begin
          // free list empty: byte dropped, put abandoned
          ov_nxt       = 1'b1;
          o_status_nxt = 1'b1;
          o_free_nxt   = free_total_r;
          put_busy_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end else begin
          o_status_nxt = 1'b0;
          if (need_pop) begin
            free_head_nxt  = link_rd_r;
            free_total_nxt = free_total_r - 1'b1;
          end
          if (!put_busy_r) begin
            put_first_nxt = put_blk;
          end
          if (put_busy_r && need_pop) begin
            hdr_we    = 1'b1;
            hdr_waddr = put_cur_r;
            hdr_wdata = STAMP_W'(put_blk);
          end
          put_cur_nxt  = put_blk;
          put_fill_nxt = put_idx + 1'b1;
          pay_we       = 1'b1;
          pay_waddr    = ADDR_W'(put_blk) * ADDR_W'(PAYLOAD_BYTES) + ADDR_W'(put_idx);
          pay_wdata    = item_r.data_byte;
          if (item_r.last_byte) begin
            put_busy_nxt = 1'b0;
            if (put_busy_r && need_pop) begin
              state_nxt = S_PUT_STAMP;
            end else begin
              hdr_we       = 1'b1;
              hdr_waddr    = put_blk;
              hdr_wdata    = item_r.stamp_in;
              ov_nxt       = 1'b1;
              o_eod_nxt    = 1'b1;
              o_loc_nxt    = put_busy_r ? put_first_r : put_blk;
              o_free_nxt   = free_total_nxt;
              state_nxt    = S_IDLE;
            end
          end else begin
            put_busy_nxt = 1'b1;
            ov_nxt       = 1'b1;
            o_free_nxt   = free_total_nxt;
            state_nxt    = S_IDLE;
          end
        end
      end
      S_PUT_STAMP: begin
        hdr_we       = 1'b1;
        hdr_waddr    = put_cur_r;
        hdr_wdata    = item_r.stamp_in;
        ov_nxt       = 1'b1;
        o_status_nxt = 1'b0;
        o_loc_nxt    = put_first_r;
        o_eod_nxt    = 1'b1;
        o_free_nxt   = free_total_r;
        state_nxt    = S_IDLE;
      end
      S_RD_HDR: begin
        if (rd_left_r == '0) begin
          ov_nxt       = 1'b1;
          o_status_nxt = 1'b0;
          o_loc_nxt    = '0;
          o_data_nxt   = '0;
          o_stamp_nxt  = hdr_rd_r;
          o_eod_nxt    = 1'b1;
          o_free_nxt   = free_total_r;
          state_nxt    = S_IDLE;
        end else if (rd_pos_r >= POS_W'(PAYLOAD_BYTES)) begin
          // block exhausted: follow the link and refetch its header
          rd_cur_nxt = hdr_rd_r[BLK_W-1:0];
          rd_pos_nxt = '0;
          hdr_re     = 1'b1;
          hdr_raddr  = hdr_rd_r[BLK_W-1:0];
        end else begin
          pay_re    = 1'b1;
          pay_raddr = ADDR_W'(rd_cur_r) * ADDR_W'(PAYLOAD_BYTES) + ADDR_W'(rd_pos_r);
          state_nxt = S_RD_DATA;
        end
      end
      S_RD_DATA: begin
        rd_pos_nxt   = rd_pos_r + 1'b1;
        rd_left_nxt  = rd_left_r - 1'b1;
        ov_nxt       = 1'b1;
        o_status_nxt = 1'b0;
        o_loc_nxt    = '0;
        o_data_nxt   = pay_rd_r;
        o_eod_nxt    = (rd_left_r == LEN_W'(1));
        o_stamp_nxt  = (rd_left_r == LEN_W'(1)) ? hdr_rd_r : '0;
        o_free_nxt   = free_total_r;
        state_nxt    = S_IDLE;
      end
      S_DEL_PUSH: begin
        if (free_total_r >= CNT_W'(BLOCK_COUNT)) begin
          ov_nxt       = 1'b1;
          o_status_nxt = 1'b0;
          o_loc_nxt    = '0;
          o_data_nxt   = '0;
          o_stamp_nxt  = '0;
          o_eod_nxt    = 1'b1;
          o_free_nxt   = free_total_r;
          state_nxt    = S_IDLE;
        end else begin
          link_we        = 1'b1;
          link_waddr     = del_blk_r;
          link_wdata     = free_head_r;
          free_head_nxt  = del_blk_r;
          free_total_nxt = free_total_r + 1'b1;
          if (del_left_r <= LEN_W'(PAYLOAD_BYTES)) begin
            ov_nxt       = 1'b1;
            o_status_nxt = 1'b0;
            o_loc_nxt    = '0;
            o_data_nxt   = '0;
            o_stamp_nxt  = '0;
            o_eod_nxt    = 1'b1;
            o_free_nxt   = free_total_nxt;
            state_nxt    = S_IDLE;
          end else begin
            hdr_re       = 1'b1;
            hdr_raddr    = del_blk_r;
            del_left_nxt = del_left_r - LEN_W'(PAYLOAD_BYTES);
            state_nxt    = S_DEL_NEXT;
          end
        end
      end
      S_DEL_NEXT: begin
        del_blk_nxt = hdr_rd_r[BLK_W-1:0];
        state_nxt   = S_DEL_PUSH;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      init_cnt_r   <= '0;
      free_head_r  <= '0;
      free_total_r <= CNT_W'(BLOCK_COUNT);
      put_first_r  <= '0;
      put_cur_r    <= '0;
      put_fill_r   <= '0;
      put_busy_r   <= 1'b0;
      rd_cur_r     <= '0;
      rd_pos_r     <= '0;
      rd_left_r    <= '0;
      del_blk_r    <= '0;
      del_left_r   <= '0;
      ov_r         <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      init_cnt_r   <= init_cnt_nxt;
      free_head_r  <= free_head_nxt;
      free_total_r <= free_total_nxt;
      put_first_r  <= put_first_nxt;
      put_cur_r    <= put_cur_nxt;
      put_fill_r   <= put_fill_nxt;
      put_busy_r   <= put_busy_nxt;
      rd_cur_r     <= rd_cur_nxt;
      rd_pos_r     <= rd_pos_nxt;
      rd_left_r    <= rd_left_nxt;
      del_blk_r    <= del_blk_nxt;
      del_left_r   <= del_left_nxt;
      ov_r         <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    o_status_r <= o_status_nxt;
    o_loc_r    <= o_loc_nxt;
    o_data_r   <= o_data_nxt;
    o_stamp_r  <= o_stamp_nxt;
    o_eod_r    <= o_eod_nxt;
    o_free_r   <= o_free_nxt;
  end

  always_ff @(posedge clk) begin
    if (pay_we) begin
      pay_mem[pay_waddr] <= pay_wdata;
    end
    if (pay_re) begin
      pay_rd_r <= pay_mem[pay_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_we) begin
      hdr_mem[hdr_waddr] <= hdr_wdata;
    end
    if (hdr_re) begin
      hdr_rd_r <= hdr_mem[hdr_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (link_re) begin
      link_rd_r <= link_mem[link_raddr];
    end
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = o_status_r;
  assign out_tlast  = o_eod_r;
  assign out_tdata  = {3'b000, o_free_r, o_stamp_r, o_data_r, o_loc_r};

endmodule

[src/chained_block_store.sv]
// channel   dir  tdata (low bit up)                                   tuser              tlast
// in_       in   data_byte, start_block, length_bytes, stamp_in (72)  op, begin_read     last_byte
// out_      out  location, data_out, stamp_out, free_blocks (64)      status             end_of_data
//
// put byte: S_PUT, plus S_PUT_STAMP when the last byte links a new block (registered link read)
// read byte: registered header read, then payload read; header refetched at each block crossing
// delete: registered header read per link; one result word per input word, two-entry input queue
// after reset all BLOCK_COUNT link entries are written in S_INIT with in_tready low
// output register holds a result until taken; the back end stalls only when it is full
module chained_block_store
  import cbs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // data_byte, start_block, length_bytes, stamp_in
  input  logic [2:0]             in_tuser,   // op, begin_read
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // location, data_out, stamp_out, free_blocks
  output logic                   out_tuser,  // status
  output logic                   out_tlast
);

  q_fwd_t q_fwd;
  q_bwd_t q_bwd;

  cbs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_fwd     (q_fwd),
    .q_bwd     (q_bwd)
  );

  cbs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_fwd      (q_fwd),
    .q_bwd      (q_bwd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTHESIS
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[60:50] <= 11'(BLOCK_COUNT)))
    else $error("free count above block count");

  a_fail_not_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> !out_tlast)
    else $error("failed put marked as end of data");

  a_fail_needs_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[60:50] == 11'd0))
    else $error("no-free status with blocks left");
`endif

endmodule

[sim/testbench.sv]
module testbench;
  import cbs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic               status;
    logic [BLK_W-1:0]   location;
    logic [7:0]         data_out;
    logic [STAMP_W-1:0] stamp_out;
    logic               end_of_data;
    logic [CNT_W-1:0]   free_blocks;
  } word_res_t;

  typedef struct {
    int unsigned first;
    int unsigned len;
  } chain_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [2:0]             in_tuser;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;

  chained_block_store dut (.*);

  // predictor state
  logic [7:0]         pay_mem [0:STORE_DEPTH-1];
  logic [STAMP_W-1:0] hdr_mem [0:BLOCK_COUNT-1];
  int unsigned        link_mem [0:BLOCK_COUNT-1];
  int unsigned        free_head_p, free_cnt_p;
  int unsigned        put_first_p, put_cur_p, put_fill_p;
  bit                 put_open_p;
  int unsigned        rd_blk_p, rd_pos_p, rd_left_p;

  item_t     pending_words[$];
  word_res_t pending_res[$];
  word_res_t expected_res[$];
  chain_t    live_chains[$];
  bit        read_opened;

  int unsigned errors;
  int unsigned results_seen;
  int unsigned send_gap, recv_gap, stall_left;
  bit          stall_done;
  bit          in_took;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit take_free(output int unsigned b);
    if (free_cnt_p == 0) return 0;
    b = free_head_p;
    free_head_p = link_mem[free_head_p] % BLOCK_COUNT;
    free_cnt_p--;
    return 1;
  endfunction

  function automatic bit give_free(int unsigned b);
    if (free_cnt_p >= BLOCK_COUNT) return 0;
    link_mem[b] = free_head_p;
    free_head_p = b;
    free_cnt_p++;
    return 1;
  endfunction

  function automatic int unsigned slot_of(int unsigned b, int unsigned pos);
    return b * PAYLOAD_BYTES + (pos % PAYLOAD_BYTES);
  endfunction

  function automatic word_res_t store_step(item_t it);
    word_res_t   r;
    int unsigned b, left;
    bit          ok;
    r = '0;
    case (it.op)
      OP_PUT: begin
        ok = 1;
        if (!put_open_p) begin
          if (take_free(b)) begin
            put_first_p = b;
            put_cur_p = b;
            put_fill_p = 0;
            put_open_p = 1;
          end else ok = 0;
        end else if (put_fill_p >= PAYLOAD_BYTES) begin
          if (take_free(b)) begin
            hdr_mem[put_cur_p] = b;
            put_cur_p = b;
            put_fill_p = 0;
          end else ok = 0;
        end
        if (!ok) begin
          r.status = 1;
          put_open_p = 0;
        end else begin
          pay_mem[slot_of(put_cur_p, put_fill_p)] = it.data_byte;
          put_fill_p++;
          if (it.last_byte) begin
            hdr_mem[put_cur_p] = it.stamp_in;
            put_open_p = 0;
            r.location = put_first_p;
            r.end_of_data = 1;
          end
        end
      end
      OP_READ: begin
        if (it.begin_read) begin
          rd_blk_p = it.start_block;
          rd_pos_p = 0;
          rd_left_p = it.length_bytes;
        end
        if (rd_left_p == 0) begin
          r.end_of_data = 1;
          r.stamp_out = hdr_mem[rd_blk_p];
        end else begin
          if (rd_pos_p >= PAYLOAD_BYTES) begin
            rd_blk_p = hdr_mem[rd_blk_p] % BLOCK_COUNT;
            rd_pos_p = 0;
          end
          r.data_out = pay_mem[slot_of(rd_blk_p, rd_pos_p)];
          rd_pos_p++;
          rd_left_p--;
          if (rd_left_p == 0) begin
            r.end_of_data = 1;
            r.stamp_out = hdr_mem[rd_blk_p];
          end
        end
      end
      OP_DEL: begin
        b = it.start_block;
        left = it.length_bytes;
        forever begin
          if (!give_free(b)) break;
          if (left <= PAYLOAD_BYTES) break;
          b = hdr_mem[b] % BLOCK_COUNT;
          left -= PAYLOAD_BYTES;
        end
        r.end_of_data = 1;
      end
      default: ;
    endcase
    r.free_blocks = free_cnt_p;
    return r;
  endfunction

  function automatic item_t rand_word(op_t op);
    item_t it;
    it.op = op;
    it.data_byte = $urandom;
    it.last_byte = 0;
    it.begin_read = 0;
    it.start_block = $urandom;
    it.length_bytes = $urandom;
    it.stamp_in = $urandom;
    return it;
  endfunction

  function automatic word_res_t offer(item_t it);
    word_res_t r;
    r = store_step(it);
    pending_words.push_back(it);
    pending_res.push_back(r);
    return r;
  endfunction

  task automatic put_chain(int unsigned n, bit [7:0] fixed_byte = 0, bit use_fixed = 0);
    item_t     it;
    word_res_t r;
    chain_t    c;
    for (int unsigned i = 0; i < n; i++) begin
      it = rand_word(OP_PUT);
      if (use_fixed) it.data_byte = fixed_byte;
      it.last_byte = (i == n - 1);
      r = offer(it);
      if (r.end_of_data && !r.status) begin
        c.first = r.location;
        c.len = n;
        live_chains.push_back(c);
      end
    end
  endtask

  task automatic read_chain(int idx, int unsigned n, bit [LEN_W-1:0] len);
    item_t     it;
    word_res_t r;
    for (int unsigned i = 0; i < n; i++) begin
      it = rand_word(OP_READ);
      it.begin_read = (i == 0);
      it.start_block = live_chains[idx].first;
      it.length_bytes = len;
      r = offer(it);
    end
    read_opened = 1;
  endtask

  task automatic del_chain(int idx, bit [LEN_W-1:0] len);
    item_t     it;
    word_res_t r;
    it = rand_word(OP_DEL);
    it.start_block = live_chains[idx].first;
    it.length_bytes = len;
    r = offer(it);
    live_chains.delete(idx);
  endtask

  task automatic drain();
    wait (pending_words.size() == 0 && !in_tvalid && expected_res.size() == 0);
  endtask

  // sender: one word offered until taken, random gaps between words
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_took) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          item_t it;
          it = pending_words.pop_front();
          in_tdata <= {6'b0, it.stamp_in, it.length_bytes, it.start_block, it.data_byte};
          in_tuser <= {it.begin_read, it.op};
          in_tlast <= it.last_byte;
          in_tvalid <= 1'b1;
          send_gap <= gap_len();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_tready <= 1'b0;
      end else if (!stall_done && results_seen >= 150) begin
        stall_done <= 1'b1;
        stall_left <= 400;
        out_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        recv_gap <= gap_len();
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    word_res_t got, want;
    in_took <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) expected_res.push_back(pending_res.pop_front());
    if (rst_n && out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
      got.status = out_tuser;
      got.location = out_tdata[9:0];
      got.data_out = out_tdata[17:10];
      got.stamp_out = out_tdata[49:18];
      got.end_of_data = out_tlast;
      got.free_blocks = out_tdata[60:50];
      if (expected_res.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h", got);
      end else begin
        want = expected_res.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: status %0d/%0d loc %0d/%0d data %h/%h stamp %h/%h eod %0d/%0d free %0d/%0d",
                     want.status, got.status, want.location, got.location,
                     want.data_out, got.data_out, want.stamp_out, got.stamp_out,
                     want.end_of_data, got.end_of_data, want.free_blocks, got.free_blocks);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    item_t       it;
    word_res_t   r;
    int unsigned done_words, pick, n, k;
    errors = 0;
    results_seen = 0;
    send_gap = 0;
    recv_gap = 0;
    stall_left = 0;
    stall_done = 0;
    in_took = 0;
    read_opened = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    for (int i = 0; i < BLOCK_COUNT; i++) link_mem[i] = (i + 1) % BLOCK_COUNT;
    free_head_p = 0;
    free_cnt_p = BLOCK_COUNT;
    put_first_p = 0;
    put_cur_p = 0;
    put_fill_p = 0;
    put_open_p = 0;
    rd_blk_p = 0;
    rd_pos_p = 0;
    rd_left_p = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: delete onto a full list, no-op, extreme bytes
    it = rand_word(OP_DEL);
    it.start_block = 0;
    it.length_bytes = 0;
    r = offer(it);
    r = offer(rand_word(OP_NOP));
    put_chain(1, 8'h00, 1);
    put_chain(3, 8'hff, 1);
    // last byte lands on a fresh block
    put_chain(PAYLOAD_BYTES + 1);
    read_chain(live_chains.size() - 1, PAYLOAD_BYTES + 2, PAYLOAD_BYTES + 1);
    read_chain(0, 1, 0);
    del_chain(1, 0);
    del_chain(live_chains.size() - 1, PAYLOAD_BYTES + 1);
    drain();

    // run the free list dry, one-byte puts, then fail mid-put and on a fresh put
    while (free_cnt_p > 1) put_chain(1);
    put_chain(PAYLOAD_BYTES + 10);
    put_chain(2);
    while (live_chains.size() > 0) del_chain($urandom_range(0, live_chains.size() - 1),
                                             live_chains[0].len);
    drain();

    done_words = pending_words.size();
    done_words = 0;
    while (done_words < 400) begin
      pick = $urandom_range(0, 99);
      n = pending_words.size();
      if (free_cnt_p < 60 && live_chains.size() > 0) pick = 80;
      if (pick < 35) begin
        k = ($urandom_range(0, 9) == 0) ? $urandom_range(61, 200) : $urandom_range(1, 70);
        put_chain(k);
      end else if (pick < 70 && live_chains.size() > 0) begin
        pick = $urandom_range(0, live_chains.size() - 1);
        k = $urandom_range(1, live_chains[pick].len);
        read_chain(pick, k, ($urandom_range(0, 3) == 0) ? $urandom : live_chains[pick].len);
      end else if (pick < 88 && live_chains.size() > 0) begin
        pick = $urandom_range(0, live_chains.size() - 1);
        del_chain(pick, ($urandom_range(0, 4) == 0) ?
                  $urandom_range(0, live_chains[pick].len) : live_chains[pick].len);
      end else if (pick < 94 || !read_opened || rd_left_p != 0) begin
        r = offer(rand_word(OP_NOP));
      end else begin
        // read word past the end of a read, no begin
        r = offer(rand_word(OP_READ));
      end
      done_words += pending_words.size() - n;
      if (done_words > 200 && done_words < 230) begin
        drain();
        done_words = 230;
      end
    end

    wait (pending_words.size() == 0 && !in_tvalid);
    wait (expected_res.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_res.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[files.f]
src/cbs_pkg.sv
src/cbs_front.sv
src/cbs_back.sv
src/chained_block_store.sv
sim/testbench.sv
